// ===== design/assert_macros.svh =====
// Assertion macros shared by the transmit queue framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, switched off while reset is asserted.
`define CTQSF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds.
`define CTQSF_NEVER(lbl, clk, rst_n, expr, msg) \
	`CTQSF_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== design/ctqsf_pkg.sv =====
// Types, codes, byte constants and microcode program of the transmit queue framer.
package ctqsf_pkg;

	localparam int CAP_W     = 5;
	localparam int ID_W      = 29;
	localparam int LEN_W     = 4;
	localparam int PL_W      = 64;
	localparam int NBUF      = 3;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;
	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 5;
	localparam int M_TUSER_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [LEN_W-1:0] MAX_DATA_BYTES = 4'd8;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_Q0_CAP = 2'd0;
	localparam logic [1:0] REG_Q1_CAP = 2'd1;
	localparam logic [1:0] REG_Q2_CAP = 2'd2;

	// SPI command bytes.
	localparam logic [7:0] SPI_LOAD_TX   = 8'h40;
	localparam logic [7:0] SPI_RTS       = 8'h80;
	localparam logic [7:0] SPI_BIT_MOD   = 8'h05;
	localparam logic [7:0] SPI_INT_FLAG  = 8'h2C;
	localparam logic [7:0] SPI_EXIDE     = 8'h08;
	localparam logic [7:0] SPI_TXIF0     = 8'h04;
	localparam logic [7:0] DLC_RTR       = 8'h40;

	typedef logic [1:0] bufsel_t;

	typedef struct packed {
		logic [PL_W-1:0]  payload;
		logic             extended;
		logic             remote;
		logic [LEN_W-1:0] length;
		logic [ID_W-1:0]  identifier;
	} qentry_t;

	typedef logic [3:0] pc_t;

	localparam pc_t PC_SEND  = 4'd0;
	localparam pc_t PC_QUEUE = 4'd1;
	localparam pc_t PC_EMPTY = 4'd2;
	localparam pc_t PC_BMASK = 4'd4;
	localparam pc_t PC_BDATA = 4'd5;
	localparam pc_t PC_FRAME = 4'd6;
	localparam pc_t PC_DLC   = 4'd11;
	localparam pc_t PC_DATA  = 4'd12;
	localparam pc_t PC_RTS   = 4'd13;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_LOAD, SRC_SIDH, SRC_SIDL, SRC_EID8, SRC_EID0, SRC_DLC,
		SRC_DATA, SRC_RTS, SRC_BM_CMD, SRC_BM_ADDR, SRC_BM_MASK
	} src_t;

	typedef enum logic [2:0] {
		COND_FREE, COND_ROOM, COND_NONEMPTY, COND_NODATA, COND_LAST_DATA
	} cond_t;

	typedef enum logic [1:0] {REL_NO, REL_YES, REL_IF_COND} rel_t;
	typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_IF_NOT} last_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_IF, JMP_IF_NOT} jmp_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_CLAIM, ACT_ENQ, ACT_POP, ACT_CLR_K, ACT_INC_K
	} act_t;

	typedef struct packed {
		logic  emit;
		logic  valid;
		src_t  src;
		rel_t  rel;
		last_t last;
		logic  acc_cond;
		cond_t cond;
		jmp_t  jmp;
		pc_t   target;
		act_t  act;
	} ucode_t;

	// Status seen by the sequencer's condition select.
	typedef struct packed {
		logic free;
		logic room;
		logic nonempty;
		logic nodata;
		logic last_data;
	} status_t;

	// What the sequencer tells the datapath for the current step.
	typedef struct packed {
		logic   fire;
		ucode_t word;
		logic   cond;
		logic   fin;
	} step_t;

	localparam ucode_t UC_NOP = '{
		emit: 1'b0, valid: 1'b0, src: SRC_ZERO, rel: REL_NO, last: LAST_NO,
		acc_cond: 1'b0, cond: COND_FREE, jmp: JMP_NEXT, target: PC_SEND, act: ACT_NONE
	};

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = UC_NOP;
		unique case (pc)
			PC_SEND: begin
				w.cond = COND_FREE; w.jmp = JMP_IF; w.target = PC_FRAME; w.act = ACT_CLAIM;
			end
			PC_QUEUE: begin
				w.emit = 1'b1; w.last = LAST_YES; w.acc_cond = 1'b1;
				w.cond = COND_ROOM; w.act = ACT_ENQ;
			end
			PC_EMPTY: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_BM_CMD;
			end
			4'd3: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_BM_ADDR;
			end
			PC_BMASK: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_BM_MASK;
			end
			PC_BDATA: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_ZERO; w.rel = REL_YES;
				w.last = LAST_IF_NOT; w.cond = COND_NONEMPTY; w.jmp = JMP_IF;
				w.target = PC_FRAME; w.act = ACT_POP;
			end
			PC_FRAME: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_LOAD;
			end
			4'd7: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_SIDH;
			end
			4'd8: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_SIDL;
			end
			4'd9: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_EID8;
			end
			4'd10: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_EID0;
			end
			PC_DLC: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_DLC; w.rel = REL_IF_COND;
				w.cond = COND_NODATA; w.jmp = JMP_IF; w.target = PC_RTS; w.act = ACT_CLR_K;
			end
			PC_DATA: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_DATA; w.rel = REL_IF_COND;
				w.cond = COND_LAST_DATA; w.jmp = JMP_IF_NOT; w.target = PC_DATA;
				w.act = ACT_INC_K;
			end
			PC_RTS: begin
				w.emit = 1'b1; w.valid = 1'b1; w.src = SRC_RTS; w.rel = REL_YES;
				w.last = LAST_YES;
			end
			default: begin
				w.last = LAST_YES;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/ctqsf_qmem.sv =====
// Frame queue storage for all three transmit buffers, one write and one registered read port.
module ctqsf_qmem #(
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  ctqsf_pkg::qentry_t       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output ctqsf_pkg::qentry_t       rdata
);
	import ctqsf_pkg::*;

	qentry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ctqsf_seq.sv =====
// Microcode sequencer: step counter, program ROM, condition select and branching.
`include "assert_macros.svh"

module ctqsf_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               command,
	input  ctqsf_pkg::status_t status,
	input  logic               out_free,
	output logic               busy,
	output ctqsf_pkg::step_t   step
);
	import ctqsf_pkg::*;

	logic   busy_q;
	pc_t    pc_q;
	ucode_t word;
	logic   cond;
	logic   fire;
	logic   fin;
	logic   taken;

	always_comb begin
		word = ucode_rom(pc_q);
		unique case (word.cond)
			COND_FREE:      cond = status.free;
			COND_ROOM:      cond = status.room;
			COND_NONEMPTY:  cond = status.nonempty;
			COND_NODATA:    cond = status.nodata;
			COND_LAST_DATA: cond = status.last_data;
			default:        cond = 1'b0;
		endcase
		unique case (word.last)
			LAST_YES:    fin = 1'b1;
			LAST_IF_NOT: fin = !cond;
			default:     fin = 1'b0;
		endcase
		unique case (word.jmp)
			JMP_IF:     taken = cond;
			JMP_IF_NOT: taken = !cond;
			default:    taken = 1'b0;
		endcase
		// A step that emits waits until the output register can take the item.
		fire = busy_q && (!word.emit || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_SEND;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= command ? PC_EMPTY : PC_SEND;
		end else if (fire) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= taken ? word.target : pc_q + 4'd1;
			end
		end
	end

	assign busy = busy_q;
	assign step = '{fire: fire, word: word, cond: cond, fin: fin};

	`CTQSF_ASSERT(a_pc_in_program, clk, arst_n, !busy_q || (pc_q <= PC_RTS),
		"step counter left the program")
	`CTQSF_ASSERT(a_finish_goes_idle, clk, arst_n, (fire && fin) |=> !busy_q,
		"sequencer stayed busy after the final item")

endmodule

// ===== design/ctqsf_dp.sv =====
// Datapath: frame registers, buffer and queue state, SPI byte formatting and output register.
`include "assert_macros.svh"

module ctqsf_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  command,
	input  ctqsf_pkg::bufsel_t                    buffer_index,
	input  ctqsf_pkg::qentry_t                    frame_in,
	input  logic [ctqsf_pkg::CAP_W-1:0]           capacity [ctqsf_pkg::NBUF],
	input  ctqsf_pkg::step_t                      step,
	output ctqsf_pkg::status_t                    status,
	output logic                                  out_free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,
	output logic [ctqsf_pkg::M_TUSER_W-1:0]       m_tuser,
	output logic                                  m_tlast,
	output logic                                  mem_we,
	output logic [$clog2(3*QUEUE_DEPTH)-1:0]      mem_waddr,
	output ctqsf_pkg::qentry_t                    mem_wdata,
	output logic [$clog2(3*QUEUE_DEPTH)-1:0]      mem_raddr,
	input  ctqsf_pkg::qentry_t                    mem_rdata
);
	import ctqsf_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int SUM_W = IDX_W + 1;
	localparam int AW    = $clog2(3 * QUEUE_DEPTH);

	bufsel_t          b_q;
	logic             acc_q;
	qentry_t          frame_q;
	logic [2:0]       k_q;
	logic             free_q  [NBUF];
	logic [IDX_W-1:0] head_q  [NBUF];
	logic [CNT_W-1:0] count_q [NBUF];
	logic             tvalid_q;
	logic [7:0]       tdata_q;
	logic [M_TUSER_W-1:0] tuser_q;
	logic             tlast_q;

	logic [IDX_W-1:0] hd;
	logic [IDX_W-1:0] hd_next;
	logic [CNT_W-1:0] cnt;
	logic [CMP_W-1:0] cap_sel;
	logic [CMP_W-1:0] cap_eff;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail;
	logic [AW-1:0]    base;
	logic [LEN_W-1:0] nbytes;
	logic [LEN_W-1:0] ndata;
	logic [7:0]       byte_out;
	logic             rel;
	logic             acc;

	always_comb begin
		hd      = head_q[b_q];
		cnt     = count_q[b_q];
		cap_sel = CMP_W'(capacity[b_q]);
		cap_eff = (cap_sel > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_sel;
		hd_next = (hd == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : hd + IDX_W'(1);

		// Head plus count stays below twice the depth, so one subtract wraps it.
		tail_sum = SUM_W'(hd) + SUM_W'(cnt);
		tail = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
			: IDX_W'(tail_sum);
		unique case (b_q)
			2'd0:    base = '0;
			2'd1:    base = AW'(QUEUE_DEPTH);
			default: base = AW'(2 * QUEUE_DEPTH);
		endcase

		nbytes = (frame_q.length > MAX_DATA_BYTES) ? MAX_DATA_BYTES : frame_q.length;
		ndata  = frame_q.remote ? '0 : nbytes;

		status.free      = free_q[b_q];
		status.room      = CMP_W'(cnt) < cap_eff;
		status.nonempty  = (cnt != '0);
		status.nodata    = (ndata == '0);
		status.last_data = ({1'b0, k_q} + 4'd1) == ndata;
	end

	always_comb begin
		byte_out = 8'h00;
		case (step.word.src)
			SRC_LOAD: byte_out = SPI_LOAD_TX | {5'd0, b_q, 1'b0};
			SRC_SIDH: byte_out = frame_q.extended ? frame_q.identifier[28:21]
				: frame_q.identifier[10:3];
			SRC_SIDL: byte_out = frame_q.extended
				? ({frame_q.identifier[20:18], 5'd0} | SPI_EXIDE
					| {6'd0, frame_q.identifier[17:16]})
				: {frame_q.identifier[2:0], 5'd0};
			SRC_EID8: byte_out = frame_q.extended ? frame_q.identifier[15:8] : 8'h00;
			SRC_EID0: byte_out = frame_q.extended ? frame_q.identifier[7:0] : 8'h00;
			SRC_DLC:  byte_out = {4'd0, nbytes} | (frame_q.remote ? DLC_RTR : 8'h00);
			SRC_DATA: byte_out = frame_q.payload[{k_q, 3'b000} +: 8];
			SRC_RTS:  byte_out = SPI_RTS | {5'd0, b_q == 2'd2, b_q == 2'd1, b_q == 2'd0};
			SRC_BM_CMD:  byte_out = SPI_BIT_MOD;
			SRC_BM_ADDR: byte_out = SPI_INT_FLAG;
			SRC_BM_MASK: byte_out = SPI_TXIF0 << b_q;
			default:  byte_out = 8'h00;
		endcase
		case (step.word.rel)
			REL_YES:     rel = 1'b1;
			REL_IF_COND: rel = step.cond;
			default:     rel = 1'b0;
		endcase
		acc = step.word.acc_cond ? step.cond : acc_q;
	end

	assign out_free  = !tvalid_q || m_tready;
	assign mem_we    = step.fire && (step.word.act == ACT_ENQ) && step.cond;
	assign mem_waddr = base + AW'(tail);
	assign mem_wdata = frame_q;
	// The head entry is read every cycle; it is settled well before the pop step.
	assign mem_raddr = base + AW'(hd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBUF; i++) begin
				free_q[i]  <= 1'b1;
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			tvalid_q <= 1'b0;
		end else begin
			if (step.fire) begin
				unique case (step.word.act)
					ACT_CLAIM: begin
						if (step.cond) begin
							free_q[b_q] <= 1'b0;
						end
					end
					ACT_ENQ: begin
						if (step.cond) begin
							count_q[b_q] <= cnt + CNT_W'(1);
						end
					end
					ACT_POP: begin
						if (step.cond) begin
							head_q[b_q]  <= hd_next;
							count_q[b_q] <= cnt - CNT_W'(1);
						end else begin
							free_q[b_q] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (step.fire && step.word.emit) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			b_q     <= (buffer_index == 2'd3) ? 2'd0 : buffer_index;
			acc_q   <= !command;
			frame_q <= frame_in;
		end else if (step.fire && (step.word.act == ACT_POP) && step.cond) begin
			frame_q <= mem_rdata;
		end
		if (step.fire && (step.word.act == ACT_CLR_K)) begin
			k_q <= '0;
		end else if (step.fire && (step.word.act == ACT_INC_K)) begin
			k_q <= k_q + 3'd1;
		end
		if (step.fire && step.word.emit) begin
			tdata_q <= step.word.valid ? byte_out : 8'h00;
			tuser_q <= {acc, rel, step.word.valid};
			tlast_q <= step.fin;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

	`CTQSF_ASSERT(a_count_bounded, clk, arst_n,
		(count_q[0] <= CNT_W'(QUEUE_DEPTH)) && (count_q[1] <= CNT_W'(QUEUE_DEPTH))
		&& (count_q[2] <= CNT_W'(QUEUE_DEPTH)),
		"queue count above queue depth")
	`CTQSF_ASSERT(a_free_means_empty, clk, arst_n,
		(!free_q[0] || (count_q[0] == '0)) && (!free_q[1] || (count_q[1] == '0))
		&& (!free_q[2] || (count_q[2] == '0)),
		"free transmit buffer with frames still queued")

endmodule

// ===== design/can_tx_queue_spi_framer.sv =====
// Top level of the CAN transmit queue SPI framer: stream ports, register port and submodules.

// An item is taken in, a send request then passes a decision step, and the item then gives
// its results: a send request to a free buffer gives 7 to 15 SPI bytes, a queued or refused
// request one status item, and a buffer-empty event 4 flag-clear bytes plus up to 15 bytes of
// the next queued frame, at most 19 results. The microcode step counter emits one result per
// cycle into a single output register while that register is free, and m_tready stalls hold it.
// A new item is taken once the final result of the previous one sits in the output register.
// Queue storage is not cleared after reset; only counted entries are used.
module can_tx_queue_spi_framer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// identifier [28:0], length [32:29], payload [96:33], zero [103:97]
	input  logic [ctqsf_pkg::S_TDATA_W-1:0]     s_tdata,
	// command [0], buffer_index [2:1], extended [3], remote [4]
	input  logic [ctqsf_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// spi_byte [7:0]
	output logic [7:0]                          m_tdata,
	// byte_valid [0], release_select [1], accepted [2]
	output logic [ctqsf_pkg::M_TUSER_W-1:0]     m_tuser,
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ctqsf_pkg::APB_AW-1:0]        paddr,
	input  logic [ctqsf_pkg::APB_DW-1:0]        pwdata,
	output logic [ctqsf_pkg::APB_DW-1:0]        prdata,
	output logic                                pready
);
	import ctqsf_pkg::*;

	localparam int MEM_DEPTH = 3 * QUEUE_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);

	logic [CAP_W-1:0] cap_q [NBUF];
	logic             busy;
	logic             start;
	logic             out_free;
	status_t          status;
	step_t            step;
	qentry_t          frame_in;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	qentry_t          mem_wdata;
	qentry_t          mem_rdata;
	logic [1:0]       reg_idx;

	assign s_tready = !busy;
	assign start    = s_tvalid && !busy;

	assign frame_in = '{
		payload:    s_tdata[96:33],
		extended:   s_tuser[3],
		remote:     s_tuser[4],
		length:     s_tdata[32:29],
		identifier: s_tdata[28:0]
	};

	// Register port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBUF; i++) begin
				cap_q[i] <= CAP_RESET;
			end
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_Q0_CAP: cap_q[0] <= pwdata[CAP_W-1:0];
				REG_Q1_CAP: cap_q[1] <= pwdata[CAP_W-1:0];
				REG_Q2_CAP: cap_q[2] <= pwdata[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_Q0_CAP: prdata = APB_DW'(cap_q[0]);
			REG_Q1_CAP: prdata = APB_DW'(cap_q[1]);
			REG_Q2_CAP: prdata = APB_DW'(cap_q[2]);
			default:    prdata = '0;
		endcase
	end

	ctqsf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.command  (s_tuser[0]),
		.status   (status),
		.out_free (out_free),
		.busy     (busy),
		.step     (step)
	);

	ctqsf_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (s_tuser[0]),
		.buffer_index (s_tuser[2:1]),
		.frame_in     (frame_in),
		.capacity     (cap_q),
		.step         (step),
		.status       (status),
		.out_free     (out_free),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	ctqsf_qmem #(
		.DEPTH (MEM_DEPTH)
	) u_qmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// ===== bench/can_tx_queue_spi_framer_test.sv =====
// Self-checking testbench for the CAN transmit queue SPI framer with a predicting scoreboard.
`timescale 1ns / 100ps

module can_tx_queue_spi_framer_test;
	import ctqsf_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 58;
	localparam int DRAIN_CYCLES = 25;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_GAP = 12;
	localparam int RANDOM_CAP = 99;
	localparam longint TIMEOUT_NS = 30_000_000;

	localparam logic CMD_SEND  = 1'b0;
	localparam logic CMD_EMPTY = 1'b1;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic       command;
		logic [1:0] buffer_index;
		qentry_t    frame;
	} can_request_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       byte_valid;
		logic       release_select;
		logic       accepted;
		logic       last;
	} spi_result_t;

	class spi_frame_scoreboard;
		logic [CAP_W-1:0] capacity [NBUF];
		bit               buffer_free [NBUF];
		qentry_t          waiting [NBUF][$];
		spi_result_t      expected [$];
		int unsigned      errors, checked, sends, queued, refused, empties;

		function new();
			foreach (capacity[i]) begin
				capacity[i] = CAP_RESET;
				buffer_free[i] = 1'b1;
			end
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void write_reg(input logic [1:0] reg_index, input logic [APB_DW-1:0] value);
			if (reg_index != REG_NONE)
				capacity[reg_index] = value[CAP_W-1:0];
		endfunction

		function int unsigned pending();
			return expected.size();
		endfunction

		function void push_byte(input logic [7:0] data, input logic valid, input logic rel,
				input logic acc);
			spi_result_t r;
			r.spi_byte = data;
			r.byte_valid = valid;
			r.release_select = rel;
			r.accepted = acc;
			r.last = 1'b0;
			expected.push_back(r);
		endfunction

		function void serialize_frame(input logic [1:0] b, input qentry_t f, input logic acc);
			logic [LEN_W-1:0] count;
			logic [7:0]       dlc;
			int unsigned      ndata;
			count = (f.length > MAX_DATA_BYTES) ? MAX_DATA_BYTES : f.length;
			dlc = {4'b0, count} | (f.remote ? DLC_RTR : 8'h00);
			ndata = f.remote ? 0 : count;
			push_byte(SPI_LOAD_TX | {5'b0, b, 1'b0}, 1'b1, 1'b0, acc);
			if (f.extended) begin
				push_byte(f.identifier[28:21], 1'b1, 1'b0, acc);
				push_byte({f.identifier[20:18], 5'b0} | SPI_EXIDE | {6'b0, f.identifier[17:16]},
					1'b1, 1'b0, acc);
				push_byte(f.identifier[15:8], 1'b1, 1'b0, acc);
				push_byte(f.identifier[7:0], 1'b1, 1'b0, acc);
			end else begin
				push_byte(f.identifier[10:3], 1'b1, 1'b0, acc);
				push_byte({f.identifier[2:0], 5'b0}, 1'b1, 1'b0, acc);
				push_byte(8'h00, 1'b1, 1'b0, acc);
				push_byte(8'h00, 1'b1, 1'b0, acc);
			end
			push_byte(dlc, 1'b1, ndata == 0, acc);
			for (int k = 0; k < ndata; k++)
				push_byte(f.payload[8*k +: 8], 1'b1, k + 1 == ndata, acc);
			push_byte(SPI_RTS | (8'h01 << b), 1'b1, 1'b1, acc);
		endfunction

		function void note_item(input can_request_t req);
			logic [1:0]  b;
			int unsigned room;
			b = (req.buffer_index == 2'd3) ? 2'd0 : req.buffer_index;
			if (req.command == CMD_SEND) begin
				sends++;
				room = (capacity[b] > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity[b];
				if (buffer_free[b]) begin
					buffer_free[b] = 1'b0;
					serialize_frame(b, req.frame, 1'b1);
				end else if (waiting[b].size() < room) begin
					queued++;
					waiting[b].push_back(req.frame);
					push_byte(8'h00, 1'b0, 1'b0, 1'b1);
				end else begin
					refused++;
					push_byte(8'h00, 1'b0, 1'b0, 1'b0);
				end
			end else begin
				empties++;
				push_byte(SPI_BIT_MOD, 1'b1, 1'b0, 1'b0);
				push_byte(SPI_INT_FLAG, 1'b1, 1'b0, 1'b0);
				push_byte(SPI_TXIF0 << b, 1'b1, 1'b0, 1'b0);
				push_byte(8'h00, 1'b1, 1'b1, 1'b0);
				if (waiting[b].size() != 0)
					serialize_frame(b, waiting[b].pop_front(), 1'b0);
				else
					buffer_free[b] = 1'b1;
			end
			expected[expected.size() - 1].last = 1'b1;
		endfunction

		task check_result(input logic [7:0] data, input logic [M_TUSER_W-1:0] flags,
				input logic tlast);
			spi_result_t want;
			checked++;
			if (expected.size() == 0) begin
				report($sformatf("result byte %02h flags %03b last %0b with nothing expected",
					data, flags, tlast));
				return;
			end
			want = expected.pop_front();
			if (data !== want.spi_byte || flags[0] !== want.byte_valid ||
					flags[1] !== want.release_select || flags[2] !== want.accepted ||
					tlast !== want.last)
				report($sformatf({"result %0d: got byte %02h v%0b r%0b a%0b l%0b, ",
					"expected byte %02h v%0b r%0b a%0b l%0b"}, checked, data, flags[0],
					flags[1], flags[2], tlast, want.spi_byte, want.byte_valid,
					want.release_select, want.accepted, want.last));
		endtask

		task close();
			if (expected.size() != 0)
				report($sformatf("%0d expected results never arrived", expected.size()));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	spi_frame_scoreboard sb = new();
	bit          tx_calm;
	bit          rx_calm;
	int unsigned results_seen;

	can_tx_queue_spi_framer #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic can_request_t make_send(input logic [1:0] b, input logic [ID_W-1:0] id,
			input logic ext, input logic rtr, input logic [LEN_W-1:0] len,
			input logic [PL_W-1:0] pl);
		can_request_t req;
		req.command = CMD_SEND;
		req.buffer_index = b;
		req.frame.identifier = id;
		req.frame.extended = ext;
		req.frame.remote = rtr;
		req.frame.length = len;
		req.frame.payload = pl;
		return req;
	endfunction

	function automatic can_request_t make_empty(input logic [1:0] b);
		can_request_t req;
		req = '0;
		req.command = CMD_EMPTY;
		req.buffer_index = b;
		return req;
	endfunction

	// Sends dominate slightly so that the queues fill and refusals happen.
	function automatic can_request_t random_request();
		can_request_t req;
		req.command = ($urandom_range(0, 9) < 4) ? CMD_EMPTY : CMD_SEND;
		req.buffer_index = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: req.frame.identifier = '0;
			1: req.frame.identifier = '1;
			default: req.frame.identifier = ID_W'($urandom);
		endcase
		req.frame.extended = 1'($urandom);
		req.frame.remote = ($urandom_range(0, 3) == 0);
		req.frame.length = LEN_W'($urandom_range(0, 15));
		req.frame.payload = {$urandom, $urandom};
		return req;
	endfunction

	task automatic send_item(input can_request_t req);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - PL_W - LEN_W - ID_W){1'b0}}, req.frame.payload,
			req.frame.length, req.frame.identifier};
		s_tuser <= {req.frame.remote, req.frame.extended, req.buffer_index, req.command};
		do @(posedge clk); while (!s_tready);
		sb.note_item(req);
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The bus returns to idle after each write.
	task automatic apb_write(input logic [1:0] reg_index, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(reg_index, value);
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		can_request_t directed [$];
		int           plan [PHASES][NBUF];
		logic [1:0]   reg_ids [NBUF];
		int           cap;
		plan = '{'{0, 1, 31}, '{2, 3, 0}, '{16, 17, 5}, '{31, 0, 16},
			'{RANDOM_CAP, RANDOM_CAP, RANDOM_CAP}, '{RANDOM_CAP, RANDOM_CAP, RANDOM_CAP},
			'{1, 1, 1}};
		reg_ids = '{REG_Q0_CAP, REG_Q1_CAP, REG_Q2_CAP};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frames to free buffers, queueing behind busy ones, draining, empty events on free
		// buffers, buffer three standing in for zero, and length and identifier extremes.
		directed.push_back(make_send(2'd0, '0, 1'b0, 1'b0, 4'd0, '0));
		directed.push_back(make_send(2'd0, '1, 1'b1, 1'b0, 4'd15, '1));
		directed.push_back(make_send(2'd3, 29'h7FF, 1'b0, 1'b1, 4'd8, 64'h0123_4567_89AB_CDEF));
		directed.push_back(make_empty(2'd0));
		directed.push_back(make_empty(2'd3));
		directed.push_back(make_empty(2'd0));
		directed.push_back(make_empty(2'd0));
		directed.push_back(make_send(2'd1, 29'h1555_5555, 1'b1, 1'b1, 4'd15, '1));
		directed.push_back(make_send(2'd2, 29'h2AA, 1'b0, 1'b0, 4'd1, 64'hA5));
		directed.push_back(make_send(2'd2, 29'h0AAA_AAAA, 1'b1, 1'b0, 4'd7,
			64'hFEDC_BA98_7654_3210));
		directed.push_back(make_send(2'd2, 29'h1FFF_F923, 1'b0, 1'b0, 4'd9,
			64'h5A5A_F00F_3C3C_C3C3));
		directed.push_back(make_empty(2'd2));
		directed.push_back(make_empty(2'd2));
		directed.push_back(make_empty(2'd2));
		directed.push_back(make_empty(2'd1));
		directed.push_back(make_send(2'd3, 29'h0000_0123, 1'b1, 1'b0, 4'd5, 64'h1122_3344_5566));
		directed.push_back(make_send(2'd1, 29'h1FFF_F800, 1'b0, 1'b1, 4'd0, '1));
		directed.push_back(make_empty(2'd0));
		directed.push_back(make_empty(2'd1));
		directed.push_back(make_empty(2'd3));
		foreach (directed[i])
			send_item(directed[i]);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			for (int r = 0; r < NBUF; r++) begin
				cap = (plan[p][r] == RANDOM_CAP) ? $urandom_range(0, 31) : plan[p][r];
				apb_write(reg_ids[r], APB_DW'({$urandom, 5'b0}) | APB_DW'(cap));
			end
			// A write past the last register must change nothing.
			if (p == 0)
				apb_write(REG_NONE, APB_DW'({$urandom, 5'b0}));
			repeat (PHASE_ITEMS)
				send_item(random_request());
			settle();
		end

		sb.close();
		$display("covered %0d send requests (%0d queued, %0d refused) and %0d buffer-empty events",
			sb.sends, sb.queued, sb.refused, sb.empties);
		$display("over %0d capacity settings; %0d results checked, %0d mismatches",
			PHASES + 1, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Output side: random stalls per result, plus two long hold-offs that back the block up.
	initial begin : receiver
		int unsigned stall;
		stall = 0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata, m_tuser, m_tlast);
				results_seen++;
				if ($urandom_range(0, 31) == 0)
					rx_calm = !rx_calm;
				stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (results_seen == 400 || results_seen == 1800)
					stall = HOLD_CYCLES;
			end else if (stall != 0) begin
				stall--;
			end
			m_tready <= (stall == 0);
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
